FILE: rtl/subscription_table_engine_core_macros.svh
// Assertion macros used by the file that checks this block.
`ifndef SUBSCRIPTION_TABLE_ENGINE_CORE_MACROS_SVH
`define SUBSCRIPTION_TABLE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define STEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define STEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stec_pkg.sv
`timescale 1ns / 1ps
package stec_pkg;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_FIND     = 3'd1;
  localparam logic [2:0] OP_DELETE   = 3'd2;
  localparam logic [2:0] OP_ALLOC    = 3'd3;
  localparam logic [2:0] OP_ITEM_DEL = 3'd4;

  localparam logic [2:0] ST_GOOD           = 3'd0;
  localparam logic [2:0] ST_TOO_MANY_SUBS  = 3'd1;
  localparam logic [2:0] ST_BAD_SUB        = 3'd2;
  localparam logic [2:0] ST_TOO_MANY_ITEMS = 3'd3;
  localparam logic [2:0] ST_BAD_ITEM       = 3'd4;

  localparam logic [31:0] ID_MAX    = 32'hFFFF_FFFF;
  localparam logic [30:0] KA_MAX    = 31'h5555_5555;
  localparam logic [6:0]  COUNT_MAX = 7'd127;

  typedef enum logic [2:0] {
    SCAN_SID    = 3'd0,
    SCAN_SFIND  = 3'd1,
    SCAN_ISWEEP = 3'd2,
    SCAN_IFREE  = 3'd3,
    SCAN_IID    = 3'd4,
    SCAN_IDEL   = 3'd5
  } scan_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] owner_session;
    logic [31:0] subscription_number;
    logic [31:0] item_number;
    logic [31:0] publishing_interval;
    logic [31:0] requested_lifetime;
    logic [31:0] requested_keep_alive;
    logic [31:0] max_notifications;
    logic [7:0]  priority_level;
    logic        enable_publishing;
    logic [63:0] time_now;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] assigned_number;
    logic [31:0] lifetime_grant;
    logic [30:0] keep_alive_grant;
    logic [63:0] next_publish_time;
    logic [6:0]  active_item_count;
  } rsp_beat_t;

  typedef struct packed {
    logic [31:0] number;
    logic [31:0] session;
    logic [31:0] interval;
    logic [30:0] keep_alive;
    logic [31:0] lifetime;
    logic [31:0] max_notifications;
    logic [7:0]  priority_level;
    logic        enabled;
    logic [31:0] sequence_no;
    logic [63:0] next_publish;
  } sub_rec_t;

  typedef struct packed {
    logic        used;
    logic [31:0] owner;
    logic [31:0] number;
  } item_rec_t;

  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       take;
    logic       try_clr;
    logic       try_inc;
    scan_t      scan;
    logic       slot_hold;
    logic       slot_free;
    logic       sub_wr;
    logic       sub_clr;
    logic       item_wr_new;
    logic       item_wr_zero;
    logic       cnt_dn;
    logic       cnt_up;
    logic       set_st;
    logic [2:0] st;
    logic       fin;
  } dp_ctrl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sub_full;
    logic       hit;
    logic       idx_last;
    logic       try_last;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: rtl/stec_ifs.sv
`timescale 1ns / 1ps
interface stec_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] owner_session;
  logic [31:0] subscription_number;
  logic [31:0] item_number;
  logic [31:0] publishing_interval;
  logic [31:0] requested_lifetime;
  logic [31:0] requested_keep_alive;
  logic [31:0] max_notifications;
  logic [7:0]  priority_level;
  logic        enable_publishing;
  logic [63:0] time_now;

  modport source (output valid, command, owner_session, subscription_number, item_number,
                  publishing_interval, requested_lifetime, requested_keep_alive,
                  max_notifications, priority_level, enable_publishing, time_now,
                  input ready);
  modport sink (input valid, command, owner_session, subscription_number, item_number,
                publishing_interval, requested_lifetime, requested_keep_alive,
                max_notifications, priority_level, enable_publishing, time_now,
                output ready);
endinterface

interface stec_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot_index;
  logic [31:0] assigned_number;
  logic [31:0] lifetime_grant;
  logic [30:0] keep_alive_grant;
  logic [63:0] next_publish_time;
  logic [6:0]  active_item_count;

  modport source (output valid, status, slot_index, assigned_number, lifetime_grant,
                  keep_alive_grant, next_publish_time, active_item_count,
                  input ready);
  modport sink (input valid, status, slot_index, assigned_number, lifetime_grant,
                keep_alive_grant, next_publish_time, active_item_count,
                output ready);
endinterface

FILE: rtl/stec_ram.sv
`timescale 1ns / 1ps
module stec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stec_ctrl.sv
`timescale 1ns / 1ps
module stec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output stec_pkg::dp_ctrl_t  ctl,
  input  stec_pkg::dp_stat_t  stat
);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_DISPATCH = 6'b000100,
    S_READ     = 6'b001000,
    S_CHECK    = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t          state, state_next;
  stec_pkg::scan_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind  <= stec_pkg::SCAN_ISWEEP;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.scan   = kind;
    kind_next  = kind;
    state_next = state;
    cmd_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        // wipe the item table, one entry a cycle
        ctl.item_wr_zero = 1'b1;
        if (stat.idx_last) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_READ;
        unique case (stat.op)
          stec_pkg::OP_CREATE: begin
            if (stat.sub_full) begin
              ctl.set_st = 1'b1;
              ctl.st     = stec_pkg::ST_TOO_MANY_SUBS;
              state_next = S_DONE;
            end else begin
              ctl.slot_free = 1'b1;
              ctl.take      = 1'b1;
              kind_next     = stec_pkg::SCAN_SID;
            end
          end
          stec_pkg::OP_FIND, stec_pkg::OP_DELETE: kind_next = stec_pkg::SCAN_SFIND;
          stec_pkg::OP_ALLOC:    kind_next = stec_pkg::SCAN_IFREE;
          stec_pkg::OP_ITEM_DEL: kind_next = stec_pkg::SCAN_IDEL;
          default: begin
            ctl.set_st = 1'b1;
            ctl.st     = stec_pkg::ST_BAD_SUB;
            state_next = S_DONE;
          end
        endcase
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_READ;
        ctl.st     = stec_pkg::ST_GOOD;
        unique case (kind)
          stec_pkg::SCAN_SID, stec_pkg::SCAN_IID: begin
            if (stat.hit) begin
              if (stat.try_last) begin
                ctl.set_st = 1'b1;
                ctl.st     = (kind == stec_pkg::SCAN_SID) ? stec_pkg::ST_TOO_MANY_SUBS
                                                          : stec_pkg::ST_TOO_MANY_ITEMS;
                state_next = S_DONE;
              end else begin
                // ID in use: take the next candidate, restart the sweep
                ctl.take    = 1'b1;
                ctl.try_inc = 1'b1;
                ctl.idx_clr = 1'b1;
              end
            end else if (stat.idx_last) begin
              ctl.set_st = 1'b1;
              if (kind == stec_pkg::SCAN_SID) begin
                ctl.sub_wr = 1'b1;
              end else begin
                ctl.item_wr_new = 1'b1;
                ctl.cnt_up      = 1'b1;
              end
              state_next = S_DONE;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end
          stec_pkg::SCAN_SFIND: begin
            if (stat.hit) begin
              ctl.slot_hold = 1'b1;
              if (stat.op == stec_pkg::OP_DELETE) begin
                ctl.idx_clr = 1'b1;
                kind_next   = stec_pkg::SCAN_ISWEEP;
              end else begin
                ctl.set_st = 1'b1;
                state_next = S_DONE;
              end
            end else if (stat.idx_last) begin
              ctl.set_st = 1'b1;
              ctl.st     = stec_pkg::ST_BAD_SUB;
              state_next = S_DONE;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end
          stec_pkg::SCAN_ISWEEP: begin
            // drop every item owned by the deleted subscription
            if (stat.hit) begin
              ctl.item_wr_zero = 1'b1;
              ctl.cnt_dn       = 1'b1;
            end
            if (stat.idx_last) begin
              ctl.sub_clr = 1'b1;
              ctl.set_st  = 1'b1;
              state_next  = S_DONE;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end
          stec_pkg::SCAN_IFREE: begin
            if (stat.hit) begin
              ctl.slot_hold = 1'b1;
              ctl.take      = 1'b1;
              ctl.try_clr   = 1'b1;
              ctl.idx_clr   = 1'b1;
              kind_next     = stec_pkg::SCAN_IID;
            end else if (stat.idx_last) begin
              ctl.set_st = 1'b1;
              ctl.st     = stec_pkg::ST_TOO_MANY_ITEMS;
              state_next = S_DONE;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end
          stec_pkg::SCAN_IDEL: begin
            if (stat.hit) begin
              ctl.item_wr_zero = 1'b1;
              ctl.cnt_dn       = 1'b1;
              ctl.slot_hold    = 1'b1;
              ctl.set_st       = 1'b1;
              state_next       = S_DONE;
            end else if (stat.idx_last) begin
              ctl.set_st = 1'b1;
              ctl.st     = stec_pkg::ST_BAD_ITEM;
              state_next = S_DONE;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/stec_dp.sv
`timescale 1ns / 1ps
module stec_dp #(
  parameter int SUB_SLOTS  = 8,
  parameter int ITEM_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  stec_pkg::dp_ctrl_t  ctl,
  output stec_pkg::dp_stat_t  stat,
  input  stec_pkg::cmd_beat_t in_beat,
  output stec_pkg::rsp_beat_t out_beat,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int SIW  = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
  localparam int IIW  = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
  localparam int CW   = (IIW > SIW) ? IIW : SIW;
  localparam int MAXS = (ITEM_SLOTS > SUB_SLOTS) ? ITEM_SLOTS : SUB_SLOTS;
  localparam int TW   = $clog2(MAXS + 2);
  localparam int SRW  = $bits(stec_pkg::sub_rec_t);
  localparam int IRW  = $bits(stec_pkg::item_rec_t);

  stec_pkg::cmd_beat_t beat;
  logic [CW-1:0]        idx, slot;
  logic [TW-1:0]        tries;
  logic [31:0]          cand, next_sub, next_item;
  logic [6:0]           item_count;
  logic [SUB_SLOTS-1:0] sub_used;
  logic [2:0]           st_code;

  logic [SIW-1:0]       idx_s, free_idx;
  logic [IIW-1:0]       idx_i;
  logic                 is_create, item_scan;
  logic [31:0]          ctr_sel, cand_n, ctr_adv;
  logic [30:0]          ka;
  logic [31:0]          ka3, life;
  logic [63:0]          next_pub;
  stec_pkg::sub_rec_t   sub_wd, sub_rd;
  stec_pkg::item_rec_t  item_wd, item_rd;
  logic                 item_we;
  logic [IIW-1:0]       item_wa;
  logic [CW+5:0]        slot_wide;
  logic                 good;

  assign idx_s     = idx[SIW-1:0];
  assign idx_i     = idx[IIW-1:0];
  assign is_create = (beat.command == stec_pkg::OP_CREATE);

  // candidate ID: zero reads as one, wrap past all-ones back to one
  assign ctr_sel = is_create ? next_sub : next_item;
  assign cand_n  = (ctr_sel == 32'd0) ? 32'd1 : ctr_sel;
  assign ctr_adv = (cand_n == stec_pkg::ID_MAX) ? 32'd1 : cand_n + 32'd1;

  always_comb begin
    free_idx = '0;
    for (int i = SUB_SLOTS - 1; i >= 0; i--) begin
      if (!sub_used[i]) free_idx = SIW'(i);
    end
  end

  // revised counts
  always_comb begin
    if (beat.requested_keep_alive == 32'd0) begin
      ka = 31'd1;
    end else if (beat.requested_keep_alive > {1'b0, stec_pkg::KA_MAX}) begin
      ka = stec_pkg::KA_MAX;
    end else begin
      ka = beat.requested_keep_alive[30:0];
    end
  end
  assign ka3      = {1'b0, ka} * 32'd3;
  assign life     = (beat.requested_lifetime < ka3) ? ka3 : beat.requested_lifetime;
  assign next_pub = beat.time_now + {32'd0, beat.publishing_interval};

  always_comb begin
    sub_wd.number            = cand;
    sub_wd.session           = beat.owner_session;
    sub_wd.interval          = beat.publishing_interval;
    sub_wd.keep_alive        = ka;
    sub_wd.lifetime          = life;
    sub_wd.max_notifications = beat.max_notifications;
    sub_wd.priority_level    = beat.priority_level;
    sub_wd.enabled           = beat.enable_publishing;
    sub_wd.sequence_no       = 32'd1;
    sub_wd.next_publish      = next_pub;
  end

  stec_ram #(.WIDTH(SRW), .DEPTH(SUB_SLOTS)) u_sub_ram (
    .clk   (clk),
    .we    (ctl.sub_wr),
    .waddr (slot[SIW-1:0]),
    .wdata (sub_wd),
    .raddr (idx_s),
    .rdata (sub_rd)
  );

  assign item_we = ctl.item_wr_new | ctl.item_wr_zero;
  assign item_wa = ctl.item_wr_new ? slot[IIW-1:0] : idx_i;
  always_comb begin
    item_wd = '0;
    if (ctl.item_wr_new) begin
      item_wd.used   = 1'b1;
      item_wd.owner  = beat.subscription_number;
      item_wd.number = cand;
    end
  end

  stec_ram #(.WIDTH(IRW), .DEPTH(ITEM_SLOTS)) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_wa),
    .wdata (item_wd),
    .raddr (idx_i),
    .rdata (item_rd)
  );

  assign item_scan = (ctl.scan != stec_pkg::SCAN_SID) && (ctl.scan != stec_pkg::SCAN_SFIND);

  always_comb begin
    stat.op       = beat.command;
    stat.sub_full = &sub_used;
    stat.idx_last = item_scan ? (idx == CW'(ITEM_SLOTS - 1)) : (idx == CW'(SUB_SLOTS - 1));
    stat.try_last = is_create ? (tries == TW'(SUB_SLOTS)) : (tries == TW'(ITEM_SLOTS));
    stat.out_free = !out_valid || out_ready;
    unique case (ctl.scan)
      stec_pkg::SCAN_SID:    stat.hit = sub_used[idx_s] && (sub_rd.number == cand);
      stec_pkg::SCAN_SFIND:  stat.hit = sub_used[idx_s]
                                        && (sub_rd.session == beat.owner_session)
                                        && (sub_rd.number == beat.subscription_number);
      stec_pkg::SCAN_ISWEEP: stat.hit = item_rd.used
                                        && (item_rd.owner == beat.subscription_number);
      stec_pkg::SCAN_IFREE:  stat.hit = !item_rd.used;
      stec_pkg::SCAN_IID:    stat.hit = item_rd.used && (item_rd.number == cand);
      stec_pkg::SCAN_IDEL:   stat.hit = item_rd.used
                                        && (item_rd.owner == beat.subscription_number)
                                        && (item_rd.number == beat.item_number);
      default:               stat.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) beat <= in_beat;
    if (ctl.take) cand <= cand_n;
    if (ctl.slot_free) begin
      slot <= CW'(free_idx);
    end else if (ctl.slot_hold) begin
      slot <= idx;
    end
    if (ctl.set_st) st_code <= ctl.st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      tries      <= '0;
      next_sub   <= 32'd1;
      next_item  <= 32'd1;
      item_count <= '0;
      sub_used   <= '0;
    end else begin
      if (ctl.load || ctl.idx_clr) begin
        idx <= '0;
      end else if (ctl.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (ctl.load || ctl.try_clr) begin
        tries <= '0;
      end else if (ctl.try_inc) begin
        tries <= tries + TW'(1);
      end
      if (ctl.take) begin
        if (is_create) next_sub <= ctr_adv;
        else           next_item <= ctr_adv;
      end
      if (ctl.cnt_up && item_count != stec_pkg::COUNT_MAX) begin
        item_count <= item_count + 7'd1;
      end else if (ctl.cnt_dn && item_count != 7'd0) begin
        item_count <= item_count - 7'd1;
      end
      if (ctl.sub_wr)  sub_used[slot[SIW-1:0]] <= 1'b1;
      if (ctl.sub_clr) sub_used[slot[SIW-1:0]] <= 1'b0;
    end
  end

  // output register
  assign slot_wide = {6'd0, slot};
  assign good      = (st_code == stec_pkg::ST_GOOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_beat.status          <= st_code;
      out_beat.slot_index      <= good ? slot_wide[5:0] : 6'd0;
      out_beat.assigned_number <= (good && (is_create || beat.command == stec_pkg::OP_ALLOC))
                                  ? cand : 32'd0;
      out_beat.lifetime_grant    <= (good && is_create) ? life : 32'd0;
      out_beat.keep_alive_grant  <= (good && is_create) ? ka : 31'd0;
      out_beat.next_publish_time <= (good && is_create) ? next_pub : 64'd0;
      out_beat.active_item_count <= item_count;
    end
  end

endmodule

FILE: rtl/subscription_table_engine_core.sv
`timescale 1ns / 1ps
// Subscription and monitored-item table engine. One command beat in, one
// result beat out; a command is taken only when the previous one has
// finished its work, and the result waits in an output register so the
// next command can be taken while it is unread. Both tables are walked one
// entry at a time: the entry is addressed in the READ state and compared on
// the registered RAM read in the CHECK state. Find walks the subscription
// table; create walks it for the first candidate ID and again for each
// candidate found in use; delete adds a sweep over the items; item alloc
// walks the item table to find a free slot and then walks it for each
// candidate ID; item delete walks the item table. An unknown command skips
// the walks. After reset a clearing pass wipes the item table before the
// first command is taken.
`include "subscription_table_engine_core_macros.svh"
module subscription_table_engine_core #(
  parameter int SUB_SLOTS  = 8,
  parameter int ITEM_SLOTS = 64
) (
  input logic        clk,
  input logic        rst,
  stec_cmd_if.sink   cmd,
  stec_rsp_if.source rsp
);

  stec_pkg::dp_ctrl_t  ctl;
  stec_pkg::dp_stat_t  stat;
  stec_pkg::cmd_beat_t in_beat;
  stec_pkg::rsp_beat_t out_beat;
  logic                err_beat, err_clean, ka_ok;

  // gather the command beat
  always_comb begin
    in_beat.command              = cmd.command;
    in_beat.owner_session        = cmd.owner_session;
    in_beat.subscription_number  = cmd.subscription_number;
    in_beat.item_number          = cmd.item_number;
    in_beat.publishing_interval  = cmd.publishing_interval;
    in_beat.requested_lifetime   = cmd.requested_lifetime;
    in_beat.requested_keep_alive = cmd.requested_keep_alive;
    in_beat.max_notifications    = cmd.max_notifications;
    in_beat.priority_level       = cmd.priority_level;
    in_beat.enable_publishing    = cmd.enable_publishing;
    in_beat.time_now             = cmd.time_now;
  end

  // sequencer: walks the tables, decides the result status
  stec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  // tables, ID counters, item count and output register
  stec_dp #(.SUB_SLOTS(SUB_SLOTS), .ITEM_SLOTS(ITEM_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .in_beat   (in_beat),
    .out_beat  (out_beat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
  );

  // drive the result beat
  assign rsp.status            = out_beat.status;
  assign rsp.slot_index        = out_beat.slot_index;
  assign rsp.assigned_number   = out_beat.assigned_number;
  assign rsp.lifetime_grant    = out_beat.lifetime_grant;
  assign rsp.keep_alive_grant  = out_beat.keep_alive_grant;
  assign rsp.next_publish_time = out_beat.next_publish_time;
  assign rsp.active_item_count = out_beat.active_item_count;

  assign err_beat  = rsp.valid && (rsp.status != stec_pkg::ST_GOOD);
  assign err_clean = (rsp.slot_index == 6'd0) && (rsp.assigned_number == 32'd0);
  assign ka_ok     = (rsp.keep_alive_grant <= stec_pkg::KA_MAX);

  // an error result never names a slot or hands out an ID
  `STEC_ASSERT_NOW(a_err_clean, err_beat, err_clean, "error result carries slot or id")
  // keep-alive on any result stays within the clamp
  `STEC_ASSERT_NOW(a_ka_clamp, rsp.valid, ka_ok, "keep-alive above clamp")
  // one command in work at a time
  `STEC_ASSERT_NEXT(a_one_cmd, cmd.valid && cmd.ready, !cmd.ready, "command taken while busy")

endmodule
